// ===== design/nmea_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checker package
// Shared types, character codes, header table and hex digit decoding.
// ---------------------------------------------------------------------------
package nmea_pkg;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_BODY = 2'd1,
        MODE_SUM  = 2'd2
    } t_mode;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_START = 8'h24;  // '$'
    localparam t_char CHAR_STAR  = 8'h2A;  // '*'
    localparam t_char CHAR_COMMA = 8'h2C;  // ','

    localparam int NUM_TYPES  = 6;
    localparam int HDR_LEN    = 5;

    localparam logic [2:0] TYPE_GGA   = 3'd0;
    localparam logic [2:0] TYPE_GLL   = 3'd1;
    localparam logic [2:0] TYPE_GSA   = 3'd2;
    localparam logic [2:0] TYPE_GSV   = 3'd3;
    localparam logic [2:0] TYPE_RMC   = 3'd4;
    localparam logic [2:0] TYPE_VTG   = 3'd5;
    localparam logic [2:0] TYPE_OTHER = 3'd6;

    typedef t_char t_hdr_row [HDR_LEN];

    // Row order follows the type codes above.
    localparam t_hdr_row HDR_TABLE [NUM_TYPES] = '{
        '{"G", "P", "G", "G", "A"},
        '{"G", "P", "G", "L", "L"},
        '{"G", "P", "G", "S", "A"},
        '{"G", "P", "G", "S", "V"},
        '{"G", "P", "R", "M", "C"},
        '{"G", "P", "V", "T", "G"}
    };

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input t_char c);
        t_hex h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= "0" && c <= "9") begin
            h.valid = 1'b1;
            h.value = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            h.valid = 1'b1;
            h.value = 4'(c - "A" + 8'd10);
        end else if (c >= "a" && c <= "f") begin
            h.valid = 1'b1;
            h.value = 4'(c - "a" + 8'd10);
        end
        return h;
    endfunction

endpackage

// ===== design/nmea_sentence_checker.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checker
// Tags each received character with field information and checks the
// XOR checksum of each sentence against its hex trailer.
// ---------------------------------------------------------------------------
// One request carries one received character; each produces exactly one
// result in the next cycle, and a new character is taken every cycle.
// The only limit on rate is the single result register: a character is
// held off only while a finished result waits under stall. Outside a
// sentence the block hunts for '$'. Body bytes are XORed and tagged with
// their comma field number (saturating at the smaller of MAX_FIELD and
// 63). The first five body bytes select the sentence type. After '*' hex
// digits are read, and the first non-hex byte reports sentence_done with
// checksum_ok and sentence_type; a '$' there also opens the next sentence.
// A '$' inside a body restarts the sentence silently.
// ---------------------------------------------------------------------------
module nmea_sentence_checker #(
    parameter int MAX_FIELD = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  nmea_pkg::t_char      i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output nmea_pkg::t_char      o_echo_byte,
    output logic [5:0]           o_field_number,
    output logic                 o_is_field_char,
    output logic                 o_in_sentence,
    output logic                 o_sentence_done,
    output logic                 o_checksum_ok,
    output logic [2:0]           o_sentence_type,
    output nmea_pkg::t_char      o_computed_sum
);
    import nmea_pkg::*;

    localparam logic [5:0] FIELD_LIMIT = (MAX_FIELD < 63) ? 6'(MAX_FIELD) : 6'd63;

    // Parser state
    t_mode      r_mode,   n_mode;
    t_char      r_xor,    n_xor;
    logic [2:0] r_hpos,   n_hpos;
    logic [5:0] r_hmask,  n_hmask;
    logic [5:0] r_field,  n_field;
    t_char      r_hex,    n_hex;
    logic [1:0] r_hcnt,   n_hcnt;

    // Result register
    logic       r_out_valid;
    t_char      r_echo;
    logic [5:0] r_fnum,  n_fnum;
    logic       r_fchar, n_fchar;
    logic       r_insent, n_insent;
    logic       r_done,  n_done;
    logic       r_ok,    n_ok;
    logic [2:0] r_type,  n_type;
    t_char      r_sum,   n_sum;

    logic       accept;
    t_hex       hex;
    logic [2:0] dec_type;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign hex     = hex_decode(i_rx_byte);

    // Lowest matching header wins; short headers are other.
    always_comb begin
        dec_type = TYPE_OTHER;
        if (r_hpos >= 3'(HDR_LEN)) begin
            for (int t = NUM_TYPES - 1; t >= 0; t--) begin
                if (r_hmask[t]) begin
                    dec_type = 3'(t);
                end
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_xor    = r_xor;
        n_hpos   = r_hpos;
        n_hmask  = r_hmask;
        n_field  = r_field;
        n_hex    = r_hex;
        n_hcnt   = r_hcnt;
        n_fnum   = 6'd0;
        n_fchar  = 1'b0;
        n_insent = 1'b0;
        n_done   = 1'b0;
        n_ok     = 1'b0;
        n_type   = 3'd0;
        n_sum    = 8'd0;

        case (r_mode)
            MODE_BODY: begin
                if (i_rx_byte == CHAR_START) begin
                    n_mode   = MODE_BODY;
                    n_xor    = 8'd0;
                    n_hpos   = 3'd0;
                    n_hmask  = '1;
                    n_field  = 6'd0;
                    n_hex    = 8'd0;
                    n_hcnt   = 2'd0;
                    n_insent = 1'b1;
                    n_sum    = 8'd0;
                end else if (i_rx_byte == CHAR_STAR) begin
                    n_mode   = MODE_SUM;
                    n_hex    = 8'd0;
                    n_hcnt   = 2'd0;
                    n_insent = 1'b1;
                    n_fnum   = r_field;
                    n_sum    = r_xor;
                end else begin
                    n_xor = r_xor ^ i_rx_byte;
                    if (r_hpos < 3'(HDR_LEN)) begin
                        for (int t = 0; t < NUM_TYPES; t++) begin
                            if (HDR_TABLE[t][r_hpos] != i_rx_byte) begin
                                n_hmask[t] = 1'b0;
                            end
                        end
                        n_hpos = r_hpos + 3'd1;
                    end
                    n_insent = 1'b1;
                    n_fnum   = r_field;
                    if (i_rx_byte == CHAR_COMMA) begin
                        if (r_field < FIELD_LIMIT) begin
                            n_field = r_field + 6'd1;
                        end
                    end else begin
                        n_fchar = 1'b1;
                    end
                    n_sum = r_xor ^ i_rx_byte;
                end
            end
            MODE_SUM: begin
                n_fnum = r_field;
                n_sum  = r_xor;
                if (hex.valid) begin
                    n_hex    = {r_hex[3:0], hex.value};
                    if (r_hcnt != 2'd3) begin
                        n_hcnt = r_hcnt + 2'd1;
                    end
                    n_insent = 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_ok    = (r_hcnt == 2'd1 || r_hcnt == 2'd2) && (r_hex == r_xor);
                    n_type  = dec_type;
                    n_mode  = (i_rx_byte == CHAR_START) ? MODE_BODY : MODE_HUNT;
                    n_xor   = 8'd0;
                    n_hpos  = 3'd0;
                    n_hmask = '1;
                    n_field = 6'd0;
                    n_hex   = 8'd0;
                    n_hcnt  = 2'd0;
                    n_insent = (i_rx_byte == CHAR_START);
                end
            end
            default: begin
                if (i_rx_byte == CHAR_START) begin
                    n_mode   = MODE_BODY;
                    n_xor    = 8'd0;
                    n_hpos   = 3'd0;
                    n_hmask  = '1;
                    n_field  = 6'd0;
                    n_hex    = 8'd0;
                    n_hcnt   = 2'd0;
                    n_insent = 1'b1;
                end else begin
                    n_mode = MODE_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_xor   <= 8'd0;
            r_hpos  <= 3'd0;
            r_hmask <= '1;
            r_field <= 6'd0;
            r_hex   <= 8'd0;
            r_hcnt  <= 2'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_xor   <= n_xor;
            r_hpos  <= n_hpos;
            r_hmask <= n_hmask;
            r_field <= n_field;
            r_hex   <= n_hex;
            r_hcnt  <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_echo   <= i_rx_byte;
            r_fnum   <= n_fnum;
            r_fchar  <= n_fchar;
            r_insent <= n_insent;
            r_done   <= n_done;
            r_ok     <= n_ok;
            r_type   <= n_type;
            r_sum    <= n_sum;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_echo_byte     = r_echo;
    assign o_field_number  = r_fnum;
    assign o_is_field_char = r_fchar;
    assign o_in_sentence   = r_insent;
    assign o_sentence_done = r_done;
    assign o_checksum_ok   = r_ok;
    assign o_sentence_type = r_type;
    assign o_computed_sum  = r_sum;

    // While hunting, no sentence context may linger.
    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HUNT |-> r_xor == 8'd0 && r_field == 6'd0 && r_hcnt == 2'd0)
        else $error("stale sentence state while hunting");

    // Digits are only counted in the checksum phase.
    a_hcnt_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt != 2'd0 |-> r_mode == MODE_SUM)
        else $error("hex digit count outside checksum phase");

    // Completion flags only appear with sentence_done.
    a_done_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sentence_done |-> !o_checksum_ok && o_sentence_type == TYPE_GGA)
        else $error("checksum or type reported without completion");

    // Field content is always inside a sentence.
    a_fchar_insent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_field_char |-> o_in_sentence)
        else $error("field character outside a sentence");

    // A non-start byte while hunting keeps the parser hunting.
    a_hunt_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode == MODE_HUNT && i_rx_byte != CHAR_START |=> r_mode == MODE_HUNT)
        else $error("left hunt without a start mark");

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checker testbench
// Streams received characters through the checker and compares every result
// field against a cycle-free software copy of the parser. Sentences are
// generated with good and bad checksums, all six known headers, odd headers,
// restarts and long field lists, under random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb;
    import nmea_pkg::*;

    localparam int     FIELD_CAP  = 63;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     CHAR_TOTAL = 1300;
    localparam t_char  CHAR_CR    = 8'h0D;

    typedef enum int {CK_GOOD, CK_ONE, CK_NONE, CK_THREE, CK_BAD} t_trailer;

    typedef struct packed {
        t_char      echo;
        logic [5:0] field;
        logic       content;
        logic       in_sent;
        logic       done;
        logic       sum_ok;
        logic [2:0] stype;
        t_char      sum;
    } t_char_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_char      i_rx_byte = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_char      o_echo_byte;
    logic [5:0] o_field_number;
    logic       o_is_field_char;
    logic       o_in_sentence;
    logic       o_sentence_done;
    logic       o_checksum_ok;
    logic [2:0] o_sentence_type;
    t_char      o_computed_sum;

    nmea_sentence_checker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_echo_byte     (o_echo_byte),
        .o_field_number  (o_field_number),
        .o_is_field_char (o_is_field_char),
        .o_in_sentence   (o_in_sentence),
        .o_sentence_done (o_sentence_done),
        .o_checksum_ok   (o_checksum_ok),
        .o_sentence_type (o_sentence_type),
        .o_computed_sum  (o_computed_sum)
    );

    always #2 i_clk = ~i_clk;

    // Parser copy used for prediction.
    t_mode      prs_mode = MODE_HUNT;
    t_char      prs_xor = '0;
    logic [2:0] prs_hdr_pos = '0;
    logic [5:0] prs_hdr_mask = '1;
    logic [5:0] prs_fields = '0;
    t_char      prs_hex = '0;
    logic [1:0] prs_digits = '0;

    t_char          pending_chars[$];
    t_char          sentence_body[$];
    t_char_result   char_results[$];

    int accepted_cnt = 0;
    int issued_cnt = 0;
    int results_seen = 0;
    int error_cnt = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_calm = 0;
    int hold_left = 0;
    int recv_calm = 0;
    bit pressure_done = 1'b0;

    function automatic logic [39:0] header_text(input logic [2:0] k);
        case (k)
            TYPE_GGA: return "GPGGA";
            TYPE_GLL: return "GPGLL";
            TYPE_GSA: return "GPGSA";
            TYPE_GSV: return "GPGSV";
            TYPE_RMC: return "GPRMC";
            default:  return "GPVTG";
        endcase
    endfunction

    // Returns {is_digit, value}.
    function automatic logic [4:0] hex_of(input t_char c);
        t_char base;
        base = '0;
        if (c >= "0" && c <= "9") begin
            base = "0";
            return {1'b1, 4'(c - base)};
        end else if (c >= "A" && c <= "F") begin
            base = "A";
            return {1'b1, 4'(c - base + 8'd10)};
        end else if (c >= "a" && c <= "f") begin
            base = "a";
            return {1'b1, 4'(c - base + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic t_char digit_char(input logic [3:0] n, input bit lower);
        t_char c;
        if (n < 4'd10) begin
            c = "0";
            c = c + 8'(n);
        end else begin
            c = lower ? "a" : "A";
            c = c + 8'(n) - 8'd10;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_char body_char();
        t_char c;
        c = CHAR_START;
        while (c == CHAR_START || c == CHAR_STAR || c == CHAR_COMMA) begin
            if ($urandom_range(0, 9) != 0) c = 8'($urandom_range(32, 126));
            else c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic clear_parser(input t_mode m);
        prs_mode = m;
        prs_xor = '0;
        prs_hdr_pos = '0;
        prs_hdr_mask = '1;
        prs_fields = '0;
        prs_hex = '0;
        prs_digits = '0;
    endtask

    function automatic logic [2:0] header_type();
        if (prs_hdr_pos < 3'(HDR_LEN)) return TYPE_OTHER;
        for (int t = 0; t < NUM_TYPES; t++)
            if (prs_hdr_mask[t]) return 3'(t);
        return TYPE_OTHER;
    endfunction

    task automatic parse_char(input t_char c, output t_char_result r);
        logic [4:0]  hx;
        logic [39:0] hdr;
        r = '0;
        r.echo = c;
        hx = hex_of(c);
        case (prs_mode)
            MODE_BODY: begin
                if (c == CHAR_START) begin
                    clear_parser(MODE_BODY);
                    r.in_sent = 1'b1;
                end else if (c == CHAR_STAR) begin
                    prs_mode = MODE_SUM;
                    prs_hex = '0;
                    prs_digits = '0;
                    r.in_sent = 1'b1;
                    r.field = prs_fields;
                end else begin
                    prs_xor = prs_xor ^ c;
                    if (prs_hdr_pos < 3'(HDR_LEN)) begin
                        for (int t = 0; t < NUM_TYPES; t++) begin
                            hdr = header_text(3'(t));
                            if (hdr[39 - 8 * prs_hdr_pos -: 8] != c) prs_hdr_mask[t] = 1'b0;
                        end
                        prs_hdr_pos = prs_hdr_pos + 3'd1;
                    end
                    r.in_sent = 1'b1;
                    r.field = prs_fields;
                    if (c == CHAR_COMMA) begin
                        if (prs_fields < 6'(FIELD_CAP)) prs_fields = prs_fields + 6'd1;
                    end else begin
                        r.content = 1'b1;
                    end
                end
                r.sum = prs_xor;
            end
            MODE_SUM: begin
                r.field = prs_fields;
                r.sum = prs_xor;
                if (hx[4]) begin
                    prs_hex = {prs_hex[3:0], hx[3:0]};
                    if (prs_digits < 2'd3) prs_digits = prs_digits + 2'd1;
                    r.in_sent = 1'b1;
                end else begin
                    r.done = 1'b1;
                    r.sum_ok = (prs_digits == 2'd1 || prs_digits == 2'd2) && prs_hex == prs_xor;
                    r.stype = header_type();
                    if (c == CHAR_START) begin
                        clear_parser(MODE_BODY);
                        r.in_sent = 1'b1;
                    end else begin
                        clear_parser(MODE_HUNT);
                    end
                end
            end
            default: begin
                if (c == CHAR_START) begin
                    clear_parser(MODE_BODY);
                    r.in_sent = 1'b1;
                end else begin
                    prs_mode = MODE_HUNT;
                end
            end
        endcase
    endtask

    task automatic add_header(input logic [2:0] k);
        logic [39:0] hdr;
        hdr = header_text(k);
        for (int i = 0; i < HDR_LEN; i++) sentence_body.push_back(hdr[39 - 8 * i -: 8]);
    endtask

    // Emits the collected body with its checksum trailer and terminator.
    task automatic close_sentence(input bit with_start, input t_trailer ck, input t_char term);
        t_char acc;
        bit    lower;
        acc = '0;
        lower = 1'($urandom_range(0, 1));
        if (with_start) pending_chars.push_back(CHAR_START);
        foreach (sentence_body[i]) begin
            pending_chars.push_back(sentence_body[i]);
            acc = acc ^ sentence_body[i];
        end
        sentence_body.delete();
        pending_chars.push_back(CHAR_STAR);
        case (ck)
            CK_GOOD, CK_BAD: begin
                if (ck == CK_BAD) acc = acc ^ 8'($urandom_range(1, 255));
                pending_chars.push_back(digit_char(acc[7:4], lower));
                pending_chars.push_back(digit_char(acc[3:0], lower));
            end
            CK_ONE: pending_chars.push_back(digit_char(acc[3:0], lower));
            CK_THREE: begin
                repeat (3) pending_chars.push_back(digit_char(4'($urandom_range(0, 15)), lower));
            end
            default: ;
        endcase
        pending_chars.push_back(term);
    endtask

    initial begin
        logic [39:0] hdr;
        bit          need_start;
        int          kind;
        int          pick;
        t_trailer    ck;
        t_char       term;
        t_char       noise;

        // Extremes while hunting, then a restart inside a body, a '$' that
        // terminates one sentence and opens the next, an empty header with no
        // checksum digits, and a single-digit checksum.
        pending_chars.push_back(8'h00);
        pending_chars.push_back(8'hFF);
        hdr = header_text(TYPE_VTG);
        pending_chars.push_back(CHAR_START);
        for (int i = 0; i < HDR_LEN; i++) pending_chars.push_back(hdr[39 - 8 * i -: 8]);
        add_header(TYPE_GSV);
        sentence_body.push_back(CHAR_COMMA);
        close_sentence(1'b1, CK_GOOD, CHAR_START);
        close_sentence(1'b0, CK_NONE, CHAR_CR);
        add_header(TYPE_GGA);
        close_sentence(1'b1, CK_ONE, CHAR_CR);

        need_start = 1'b1;
        while (pending_chars.size() < CHAR_TOTAL) begin
            if (need_start && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    noise = CHAR_START;
                    while (noise == CHAR_START) noise = 8'($urandom_range(0, 255));
                    pending_chars.push_back(noise);
                end
            end
            // An abandoned start, so that the real sentence restarts it.
            if (need_start && $urandom_range(0, 11) == 0) begin
                pending_chars.push_back(CHAR_START);
                repeat ($urandom_range(0, 8))
                    pending_chars.push_back($urandom_range(0, 3) == 0 ? CHAR_COMMA : body_char());
            end
            kind = $urandom_range(0, 7);
            if (kind < NUM_TYPES) begin
                add_header(3'(kind));
            end else if (kind == NUM_TYPES) begin
                repeat (HDR_LEN) sentence_body.push_back(body_char());
            end else begin
                repeat ($urandom_range(0, 4))
                    sentence_body.push_back($urandom_range(0, 2) == 0 ? CHAR_COMMA : body_char());
            end
            repeat (($urandom_range(0, 24) == 0) ? $urandom_range(62, 70) : $urandom_range(0, 8))
            begin
                sentence_body.push_back(CHAR_COMMA);
                repeat ($urandom_range(0, 5)) sentence_body.push_back(body_char());
            end
            pick = $urandom_range(0, 9);
            ck = (pick < 6) ? CK_GOOD : (pick == 6) ? CK_ONE : (pick == 7) ? CK_NONE :
                 (pick == 8) ? CK_THREE : CK_BAD;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                term = CHAR_CR;
            end else if (pick < 8) begin
                term = "0";
                while (hex_of(term) != 5'd0) term = 8'($urandom_range(0, 255));
            end else begin
                term = CHAR_START;
            end
            close_sentence(need_start, ck, term);
            need_start = (term != CHAR_START);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_chars.size() > 0 || accepted_cnt != issued_cnt || char_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Sender: holds a request until it is taken, then idles for a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && accepted_cnt != issued_cnt) begin
            i_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
            i_rx_byte <= pending_chars.pop_front();
            i_valid <= 1'b1;
            issued_cnt <= issued_cnt + 1;
            if (send_calm > 0) begin
                send_calm <= send_calm - 1;
                send_gap <= 0;
            end else if ($urandom_range(0, 149) == 0) begin
                send_calm <= 60;
                send_gap <= 0;
            end else begin
                send_gap <= pick_gap();
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off that
    // backs the block up into its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!pressure_done && results_seen >= 400) begin
            pressure_done <= 1'b1;
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (recv_calm > 0) begin
            recv_calm <= recv_calm - 1;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 299) == 0) begin
            recv_calm <= 150;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            hold_left <= pick_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_char_result pred;
        t_char_result want;
        bit           took_in;
        bit           took_out;
        took_in = i_rst_n && i_valid && !o_stall;
        took_out = i_rst_n && o_valid && !i_stall;
        if (took_in) begin
            parse_char(i_rx_byte, pred);
            char_results.push_back(pred);
            accepted_cnt <= accepted_cnt + 1;
        end
        if (took_out) begin
            results_seen <= results_seen + 1;
            if (char_results.size() == 0) begin
                $error("result received with no request outstanding");
                error_cnt++;
            end else begin
                want = char_results.pop_front();
                if (o_echo_byte !== want.echo) begin
                    $error("echo_byte: expected %0h, got %0h", want.echo, o_echo_byte);
                    error_cnt++;
                end
                if (o_field_number !== want.field) begin
                    $error("field_number: expected %0d, got %0d", want.field, o_field_number);
                    error_cnt++;
                end
                if (o_is_field_char !== want.content) begin
                    $error("is_field_char: expected %0d, got %0d", want.content,
                           o_is_field_char);
                    error_cnt++;
                end
                if (o_in_sentence !== want.in_sent) begin
                    $error("in_sentence: expected %0d, got %0d", want.in_sent, o_in_sentence);
                    error_cnt++;
                end
                if (o_sentence_done !== want.done) begin
                    $error("sentence_done: expected %0d, got %0d", want.done, o_sentence_done);
                    error_cnt++;
                end
                if (o_checksum_ok !== want.sum_ok) begin
                    $error("checksum_ok: expected %0d, got %0d", want.sum_ok, o_checksum_ok);
                    error_cnt++;
                end
                if (o_sentence_type !== want.stype) begin
                    $error("sentence_type: expected %0d, got %0d", want.stype, o_sentence_type);
                    error_cnt++;
                end
                if (o_computed_sum !== want.sum) begin
                    $error("computed_sum: expected %0h, got %0h", want.sum, o_computed_sum);
                    error_cnt++;
                end
            end
        end
        if (took_in || took_out || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== nmea_sentence_checker.f =====
design/nmea_pkg.sv
design/nmea_sentence_checker.sv
test/tb.sv
